// File: design/ppx_pkg.sv
// ---------------------------------------------------------------------------
// ppx_pkg : shared types and constants of the packed palette pixel expander
// Sizes, register indexes, format codes and the word types between modules.
// ---------------------------------------------------------------------------
package ppx_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
	localparam int PAL_W           = 32;
	localparam int BYTE_W          = 8;
	localparam int ROW_W           = 16;
	localparam int CNT_W           = 4;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 16;
	localparam int OUTQ_DEPTH      = 3;
	localparam int OUTQ_AW         = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FORMAT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 2'd2;

	// output formats
	localparam logic [1:0] FMT_INDEX = 2'd0;
	localparam logic [1:0] FMT_RGB   = 2'd1;
	localparam logic [1:0] FMT_RGBA  = 2'd2;

	// source depths
	localparam logic [1:0] DEPTH_1BPP = 2'd0;
	localparam logic [1:0] DEPTH_2BPP = 2'd1;
	localparam logic [1:0] DEPTH_4BPP = 2'd2;
	localparam logic [1:0] DEPTH_8BPP = 2'd3;

	// input word kinds
	localparam logic KIND_BYTE    = 1'b0;
	localparam logic KIND_PAL_WR  = 1'b1;

	// pixel on its way from the unpacker to the palette read stage
	typedef struct packed {
		logic [BYTE_W-1:0] idx;
		logic              in_range;
		logic              row_end;
		logic              last;
	} pix_info_t;

	// finished result word
	typedef struct packed {
		logic [BYTE_W-1:0] pixel_index;
		logic [BYTE_W-1:0] red;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] blue;
		logic [BYTE_W-1:0] alpha;
		logic              row_end;
		logic              last;
	} pix_out_t;

	function automatic logic [CNT_W-1:0] pixels_per_byte(input logic [1:0] depth);
		logic [CNT_W-1:0] n;
		case (depth)
			DEPTH_1BPP: n = 4'd8;
			DEPTH_2BPP: n = 4'd4;
			DEPTH_4BPP: n = 4'd2;
			default:    n = 4'd1;
		endcase
		return n;
	endfunction

endpackage

// File: design/ppx_if.sv
// ---------------------------------------------------------------------------
// ppx_if : channel interfaces of the packed palette pixel expander
// Input word channel, result word channel and register write channel.
// ---------------------------------------------------------------------------
interface ppx_feed_if;
	logic                           valid;
	logic                           ready;
	logic                           kind;
	logic [ppx_pkg::BYTE_W-1:0]     source_byte;
	logic [ppx_pkg::BYTE_W-1:0]     entry_number;
	logic [ppx_pkg::PAL_W-1:0]      entry_color;

	modport source (output valid, kind, source_byte, entry_number, entry_color,
		input ready);
	modport sink (input valid, kind, source_byte, entry_number, entry_color,
		output ready);
endinterface

interface ppx_pixel_if;
	logic                           valid;
	logic                           ready;
	logic [ppx_pkg::BYTE_W-1:0]     pixel_index;
	logic [ppx_pkg::BYTE_W-1:0]     red;
	logic [ppx_pkg::BYTE_W-1:0]     green;
	logic [ppx_pkg::BYTE_W-1:0]     blue;
	logic [ppx_pkg::BYTE_W-1:0]     alpha;
	logic                           row_end;
	logic                           last;

	modport source (output valid, pixel_index, red, green, blue, alpha, row_end, last,
		input ready);
	modport sink (input valid, pixel_index, red, green, blue, alpha, row_end, last,
		output ready);
endinterface

interface ppx_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [ppx_pkg::CFG_IDX_W-1:0]      index;
	logic [ppx_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: design/ppx_ram.sv
// ---------------------------------------------------------------------------
// ppx_ram : generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module ppx_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: design/ppx_unpack.sv
// ---------------------------------------------------------------------------
// ppx_unpack : byte unpacker and row counter
// Holds one source byte and hands out one pixel index per issue cycle.
// ---------------------------------------------------------------------------
module ppx_unpack (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [ppx_pkg::BYTE_W-1:0] source_byte,
	input  logic [1:0]                depth_code,
	input  logic [ppx_pkg::ROW_W-1:0] row_width,
	input  logic                      can_issue,
	output logic                      busy,
	output logic                      issue,
	output ppx_pkg::pix_info_t        info
);
	import ppx_pkg::*;

	logic [BYTE_W-1:0] sh_q;
	logic [CNT_W-1:0]  rem_q;
	logic [1:0]        dep_q;
	logic              busy_q;
	logic [ROW_W-1:0]  row_cnt_q;

	logic [BYTE_W-1:0] idx;
	logic [BYTE_W-1:0] sh_next;
	logic [ROW_W:0]    done;
	logic [ROW_W:0]    limit;
	logic              rend;
	logic              lst;

	// top pixel of the remaining bits, and the byte shifted past it
	always_comb begin
		case (dep_q)
			DEPTH_1BPP: begin
				idx     = {7'd0, sh_q[7]};
				sh_next = {sh_q[6:0], 1'b0};
			end
			DEPTH_2BPP: begin
				idx     = {6'd0, sh_q[7:6]};
				sh_next = {sh_q[5:0], 2'd0};
			end
			DEPTH_4BPP: begin
				idx     = {4'd0, sh_q[7:4]};
				sh_next = {sh_q[3:0], 4'd0};
			end
			default: begin
				idx     = sh_q;
				sh_next = '0;
			end
		endcase
	end

	// row width zero stands for a full 65536 pixel row
	assign limit = (row_width == '0) ? {1'b1, {ROW_W{1'b0}}} : {1'b0, row_width};
	assign done  = {1'b0, row_cnt_q} + {{ROW_W{1'b0}}, 1'b1};
	assign rend  = (done >= limit);
	assign lst   = rend || (rem_q == 4'd1);

	assign issue         = busy_q && can_issue;
	assign busy          = busy_q;
	assign info.idx      = idx;
	assign info.in_range = ({1'b0, idx} < 9'(PALETTE_ENTRIES));
	assign info.row_end  = rend;
	assign info.last     = lst;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			rem_q     <= '0;
			row_cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			rem_q  <= pixels_per_byte(depth_code);
		end else if (issue) begin
			busy_q    <= !lst;
			rem_q     <= rem_q - 4'd1;
			row_cnt_q <= rend ? '0 : done[ROW_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= source_byte;
			dep_q <= depth_code;
		end else if (issue) begin
			sh_q <= sh_next;
		end
	end

	a_busy_has_pixels: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q != '0)
		else $error("unpacker busy with no pixels left");

	a_last_ends_byte: assert property (@(posedge clk) disable iff (!arst_n)
		issue && lst |=> !busy_q)
		else $error("unpacker still busy after last pixel");

	a_more_keeps_busy: assert property (@(posedge clk) disable iff (!arst_n)
		issue && !lst |=> busy_q && rem_q == $past(rem_q) - 4'd1)
		else $error("unpacker lost pixels of a byte");

endmodule

// File: design/packed_palette_pixel_expander.sv
// ---------------------------------------------------------------------------
// packed_palette_pixel_expander : packed indexed pixels to index or palette color
// Unpacks 1/2/4/8 bit per pixel source bytes and looks pixels up in a palette.
// ---------------------------------------------------------------------------
// usage
//   feed   : input words. kind 0 carries a packed source byte (first pixel in
//            the top bits), kind 1 writes entry_color into palette entry
//            entry_number. a palette write yields nothing.
//   pixels : one result word per pixel: raw index always, color bytes in rgb
//            and rgba formats, row_end on the last pixel of a row, last on the
//            last pixel taken from the current byte.
//   cfg    : register writes (depth_code, output_format, row_width), always
//            ready; write them only while no byte is in flight.
// byte flow
//   the unpacker emits one pixel a cycle into a palette read while the queue
//   and read stage have room; feed is held until the last pixel of the byte
//   is issued. the first pixel of a byte passes the unpacker byte register,
//   the palette read register and the result queue before it shows on pixels.
// reset
//   clears the row counter, the queue and the registers (depth 8 bpp, index
//   format, row width 1). the palette is not cleared; entries are undefined
//   until written, and there is no clearing pass.
// stall
//   results sit in a three word queue; the unpacker only issues a palette read
//   while queue plus read stage have room, so a stalled pixels channel just
//   pauses pixel issue and then feed.
// ---------------------------------------------------------------------------
module packed_palette_pixel_expander (
	input  logic          clk,
	input  logic          arst_n,
	ppx_feed_if.sink      feed,
	ppx_pixel_if.source   pixels,
	ppx_cfg_if.sink       cfg
);
	import ppx_pkg::*;

	// configuration registers
	logic [1:0]       depth_q;
	logic [1:0]       fmt_q;
	logic [ROW_W-1:0] row_width_q;

	// unpacker side
	logic             unp_busy;
	logic             unp_issue;
	logic             can_issue;
	pix_info_t        unp_info;
	logic             feed_acc;
	logic             byte_start;
	logic             pal_we;

	// palette read stage
	logic             s1_valid_q;
	pix_info_t        info_s1;
	logic [PAL_W-1:0] pal_rdata;
	logic [PAL_W-1:0] color;
	pix_out_t         res;

	// result queue
	pix_out_t             q_mem_q [OUTQ_DEPTH];
	logic [OUTQ_AW-1:0]   head_q;
	logic [OUTQ_AW-1:0]   tail_q;
	logic [OUTQ_AW-1:0]   occ_q;
	logic                 q_pop;
	pix_out_t             q_head;

	// register write port, always ready
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= DEPTH_8BPP;
			fmt_q       <= FMT_INDEX;
			row_width_q <= 16'd1;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_DEPTH:     depth_q     <= cfg.data[1:0];
				REG_FORMAT:    fmt_q       <= cfg.data[1:0];
				REG_ROW_WIDTH: row_width_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// feed is taken only between bytes
	assign feed.ready = !unp_busy;
	assign feed_acc   = feed.valid && !unp_busy;
	assign byte_start = feed_acc && (feed.kind == KIND_BYTE);
	assign pal_we     = feed_acc && (feed.kind == KIND_PAL_WR)
		&& ({1'b0, feed.entry_number} < 9'(PALETTE_ENTRIES));

	// credit: queue words plus the one in the read stage never pass the depth
	assign can_issue = ({1'b0, occ_q} + {2'd0, s1_valid_q}) < 3'(OUTQ_DEPTH);

	ppx_unpack u_unpack (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (byte_start),
		.source_byte (feed.source_byte),
		.depth_code  (depth_q),
		.row_width   (row_width_q),
		.can_issue   (can_issue),
		.busy        (unp_busy),
		.issue       (unp_issue),
		.info        (unp_info)
	);

	// palette: writes land at accept, reads of a byte come in later cycles
	ppx_ram #(
		.WIDTH (PAL_W),
		.DEPTH (PALETTE_ENTRIES)
	) u_palette (
		.clk   (clk),
		.we    (pal_we),
		.waddr (feed.entry_number[PAL_AW-1:0]),
		.wdata (feed.entry_color),
		.re    (unp_issue),
		.raddr (unp_info.idx[PAL_AW-1:0]),
		.rdata (pal_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= unp_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (unp_issue) begin
			info_s1 <= unp_info;
		end
	end

	// indexes past the palette read as black, format 3 acts as rgb
	assign color = info_s1.in_range ? pal_rdata : '0;

	always_comb begin
		res.pixel_index = info_s1.idx;
		res.red         = (fmt_q != FMT_INDEX) ? color[7:0]   : '0;
		res.green       = (fmt_q != FMT_INDEX) ? color[15:8]  : '0;
		res.blue        = (fmt_q != FMT_INDEX) ? color[23:16] : '0;
		res.alpha       = (fmt_q == FMT_RGBA)  ? color[31:24] : '0;
		res.row_end     = info_s1.row_end;
		res.last        = info_s1.last;
	end

	// result queue, pushed from the read stage, popped by the pixels channel
	assign q_pop  = pixels.ready && (occ_q != '0);
	assign q_head = q_mem_q[head_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			occ_q  <= '0;
		end else begin
			if (s1_valid_q) begin
				tail_q <= (tail_q == 2'(OUTQ_DEPTH - 1)) ? '0 : tail_q + 2'd1;
			end
			if (q_pop) begin
				head_q <= (head_q == 2'(OUTQ_DEPTH - 1)) ? '0 : head_q + 2'd1;
			end
			occ_q <= occ_q + {1'b0, s1_valid_q} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q) begin
			q_mem_q[tail_q] <= res;
		end
	end

	assign pixels.valid       = (occ_q != '0);
	assign pixels.pixel_index = q_head.pixel_index;
	assign pixels.red         = q_head.red;
	assign pixels.green       = q_head.green;
	assign pixels.blue        = q_head.blue;
	assign pixels.alpha       = q_head.alpha;
	assign pixels.row_end     = q_head.row_end;
	assign pixels.last        = q_head.last;

	a_queue_credit: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, occ_q} + {2'd0, s1_valid_q}) <= 3'(OUTQ_DEPTH))
		else $error("result queue overrun");

	a_row_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		pixels.valid && pixels.row_end |-> pixels.last)
		else $error("row ended without closing the byte");

	a_index_mode_black: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && fmt_q == FMT_INDEX |-> res.red == '0 && res.green == '0
			&& res.blue == '0 && res.alpha == '0)
		else $error("color bytes set in index mode");

endmodule
